// ===== design/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and codes for the first-fit free-block allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_ALLOC  = 1'b1;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_NOFIT = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic        op;
        logic [31:0] block_addr;
        logic [31:0] req_size;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] alloc_addr;
    } t_out_beat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } t_state;

endpackage

// ===== design/ffa_table.sv =====
// ----------------------------------------------------------------------------
// ffa_table
// Free-block table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ffa_table #(
    parameter int DEPTH = 16,
    parameter int AW    = 32,
    parameter int IDXW  = 4
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [IDXW-1:0] i_wr_addr,
    input  logic            i_wr_valid,
    input  logic [AW-1:0]   i_wr_base,
    input  logic [31:0]     i_wr_len,
    input  logic [IDXW-1:0] i_rd_addr,
    output logic            o_rd_valid,
    output logic [AW-1:0]   o_rd_base,
    output logic [31:0]     o_rd_len
);

    localparam int WW = 1 + AW + 32;

    logic [WW-1:0] r_mem [DEPTH];
    logic [WW-1:0] r_rd_word;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_valid, i_wr_base, i_wr_len};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_word <= r_mem[i_rd_addr];
    end

    assign o_rd_valid = r_rd_word[WW-1];
    assign o_rd_base  = r_rd_word[WW-2 -: AW];
    assign o_rd_len   = r_rd_word[31:0];

endmodule

// ===== design/ffa_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffa_ctrl
// Sequencer: appends at the fill count, scans the table in slot order for
// the first fit, and writes the shrunk or retired entry back.
// ----------------------------------------------------------------------------
module ffa_ctrl #(
    parameter int MAX_BLOCKS = 16,
    parameter int AW         = 32,
    parameter int IDXW       = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  ffa_pkg::t_in_beat   i_item,
    output logic                o_done,
    output ffa_pkg::t_out_beat  o_result,
    output logic                o_wr_en,
    output logic [IDXW-1:0]     o_wr_addr,
    output logic                o_wr_valid,
    output logic [AW-1:0]       o_wr_base,
    output logic [31:0]         o_wr_len,
    output logic [IDXW-1:0]     o_rd_addr,
    input  logic                i_rd_valid,
    input  logic [AW-1:0]       i_rd_base,
    input  logic [31:0]         i_rd_len
);

    import ffa_pkg::*;

    localparam int CNTW = $clog2(MAX_BLOCKS + 1);

    t_state          r_state, n_state;
    logic [CNTW-1:0] r_count, n_count;
    logic [CNTW-1:0] r_rd_idx, n_rd_idx;
    logic [IDXW-1:0] r_ev_idx, n_ev_idx;
    logic            r_pend, n_pend;
    logic [31:0]     r_size, n_size;
    logic [IDXW-1:0] r_hit_idx, n_hit_idx;
    logic [31:0]     r_rem, n_rem;
    logic [AW-1:0]   r_base, n_base;
    logic            r_done, n_done;
    t_out_beat       r_result, n_result;

    logic            accept;
    logic            full;
    logic            issue;
    logic            hit;
    logic [AW-1:0]   sum;

    assign accept = start && (r_state == ST_IDLE);
    assign full   = (r_count == CNTW'(MAX_BLOCKS));
    assign issue  = (r_state == ST_SCAN) && (r_rd_idx < r_count);
    assign hit    = (r_state == ST_SCAN) && r_pend && i_rd_valid && (i_rd_len >= r_size);
    assign sum    = r_base + AW'(r_rem);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_item.op == OP_ALLOC) && (r_count != '0)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    n_state = ST_WRITE;
                end else if (!issue) begin
                    n_state = ST_IDLE;
                end
            end
            ST_WRITE: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_count   = r_count;
        n_rd_idx  = r_rd_idx;
        n_ev_idx  = r_rd_idx[IDXW-1:0];
        n_pend    = 1'b0;
        n_size    = r_size;
        n_hit_idx = r_hit_idx;
        n_rem     = r_rem;
        n_base    = r_base;
        n_done    = 1'b0;
        n_result  = r_result;
        o_wr_en    = 1'b0;
        o_wr_addr  = r_count[IDXW-1:0];
        o_wr_valid = 1'b1;
        o_wr_base  = AW'(i_item.block_addr);
        o_wr_len   = i_item.req_size;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_size   = i_item.req_size;
                    n_rd_idx = '0;
                    if (i_item.op == OP_APPEND) begin
                        n_done            = 1'b1;
                        n_result.alloc_addr = '0;
                        if (full) begin
                            n_result.status = STAT_FULL;
                        end else begin
                            n_result.status = STAT_OK;
                            o_wr_en         = 1'b1;
                            n_count         = r_count + 1'b1;
                        end
                    end else if (r_count == '0) begin
                        n_done              = 1'b1;
                        n_result.status     = STAT_NOFIT;
                        n_result.alloc_addr = '0;
                    end
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    n_hit_idx = r_ev_idx;
                    n_rem     = i_rd_len - r_size;
                    n_base    = i_rd_base;
                end else if (issue) begin
                    n_pend   = 1'b1;
                    n_rd_idx = r_rd_idx + 1'b1;
                end else begin
                    n_done              = 1'b1;
                    n_result.status     = STAT_NOFIT;
                    n_result.alloc_addr = '0;
                end
            end
            ST_WRITE: begin
                o_wr_en             = 1'b1;
                o_wr_addr           = r_hit_idx;
                o_wr_valid          = (r_rem != '0);
                o_wr_base           = r_base;
                o_wr_len            = r_rem;
                n_done              = 1'b1;
                n_result.status     = STAT_OK;
                n_result.alloc_addr = 32'(sum);
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx  <= n_rd_idx;
        r_ev_idx  <= n_ev_idx;
        r_size    <= n_size;
        r_hit_idx <= n_hit_idx;
        r_rem     <= n_rem;
        r_base    <= n_base;
        r_result  <= n_result;
    end

    assign o_rd_addr = r_rd_idx[IDXW-1:0];
    assign busy      = (r_state != ST_IDLE);
    assign o_done    = r_done;
    assign o_result  = r_result;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(MAX_BLOCKS))
        else $error("fill count beyond table depth");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> (r_state == ST_IDLE || r_state == ST_WRITE))
        else $error("table write during scan");

    a_append_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_item.op == OP_APPEND) |=> (r_done && r_state == ST_IDLE))
        else $error("append beat not answered next cycle");

    a_count_only_on_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(accept && i_item.op == OP_APPEND))
            |-> (r_count == $past(r_count)))
        else $error("fill count moved without an append");

    a_write_then_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE) |=> (r_done && r_result.status == STAT_OK))
        else $error("write-back without a result");
`endif

endmodule

// ===== design/first_fit_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_allocator
// First-fit allocator over an ordered table of free blocks.
// ----------------------------------------------------------------------------
// Usage:
//   Command beat: drive i_item and raise start; the beat is taken at a clock
//   edge where start is high and busy is low. op selects append or allocate.
//   Result beat: o_done pulses for one cycle with o_result (status and
//   address); it must be taken in that cycle, there is no stall.
//   Append: written into the next slot at the fill count; result in the cycle
//   after the command. Once MAX_BLOCKS appends have been made, appends
//   report table full until reset.
//   Allocate: the table memory is read one slot a cycle, pipelined against
//   the compare, then the hit entry is written back. A hit returns after the
//   slot's table read, its compare and the write-back state; a miss returns
//   once the last used slot fails its compare, or in the cycle after the
//   command on an empty table. busy stays high until the result cycle. The
//   single read port of the table sets the one-slot-per-cycle scan rate.
//   Reset: synchronous, active low; empties the table through the fill
//   count alone, so no clearing pass is needed and the block is ready at
//   once.
// ----------------------------------------------------------------------------
module first_fit_allocator #(
    parameter int MAX_BLOCKS = 16,
    parameter int ADDR_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  ffa_pkg::t_in_beat  i_item,
    output logic               o_done,
    output ffa_pkg::t_out_beat o_result
);

    import ffa_pkg::*;

    localparam int IDXW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

    logic                  wr_en;
    logic [IDXW-1:0]       wr_addr;
    logic                  wr_valid;
    logic [ADDR_WIDTH-1:0] wr_base;
    logic [31:0]           wr_len;
    logic [IDXW-1:0]       rd_addr;
    logic                  rd_valid;
    logic [ADDR_WIDTH-1:0] rd_base;
    logic [31:0]           rd_len;

    ffa_ctrl #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .AW         (ADDR_WIDTH),
        .IDXW       (IDXW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_done     (o_done),
        .o_result   (o_result),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_valid (wr_valid),
        .o_wr_base  (wr_base),
        .o_wr_len   (wr_len),
        .o_rd_addr  (rd_addr),
        .i_rd_valid (rd_valid),
        .i_rd_base  (rd_base),
        .i_rd_len   (rd_len)
    );

    ffa_table #(
        .DEPTH (MAX_BLOCKS),
        .AW    (ADDR_WIDTH),
        .IDXW  (IDXW)
    ) u_table (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_valid (wr_valid),
        .i_wr_base  (wr_base),
        .i_wr_len   (wr_len),
        .i_rd_addr  (rd_addr),
        .o_rd_valid (rd_valid),
        .o_rd_base  (rd_base),
        .o_rd_len   (rd_len)
    );

endmodule

// ===== bench/first_fit_allocator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_allocator_test
// Self-checking bench for the first-fit allocator. A short directed run hits
// empty-table misses, zero-size blocks and requests, exact fits and address
// wrap. It is followed by random command beats in phases of sender idling.
// Every result beat is checked against a local model of the free-block table.
// ----------------------------------------------------------------------------
module first_fit_allocator_test;

    import ffa_pkg::*;

    localparam int N_SLOTS      = 16;
    localparam int RANDOM_BEATS = 1436;
    localparam int TAIL_CYCLES  = 40;
    localparam int CYCLE_LIMIT  = 600000;

    class alloc_scoreboard;
        logic [31:0] slot_base [N_SLOTS];
        logic [31:0] slot_len  [N_SLOTS];
        bit          slot_valid [N_SLOTS];
        int unsigned slots_used;
        t_out_beat   expected_q [$];
        int unsigned errors;
        int unsigned n_placed, n_full, n_hit, n_miss, n_checked;

        function new();
            foreach (slot_valid[i]) slot_valid[i] = 1'b0;
            slots_used = 0;
            errors     = 0;
            n_placed   = 0;
            n_full     = 0;
            n_hit      = 0;
            n_miss     = 0;
            n_checked  = 0;
        endfunction

        // predict the result of an accepted command beat and update the table
        function void note_command(t_in_beat cmd);
            t_out_beat   res;
            logic [31:0] rest;
            bit          hit;
            int          i;
            res.status     = STAT_OK;
            res.alloc_addr = '0;
            hit            = 1'b0;
            if (cmd.op == OP_APPEND) begin
                if (slots_used >= N_SLOTS) begin
                    res.status = STAT_FULL;
                    n_full++;
                end else begin
                    slot_base[slots_used]  = cmd.block_addr;
                    slot_len[slots_used]   = cmd.req_size;
                    slot_valid[slots_used] = 1'b1;
                    slots_used++;
                    n_placed++;
                end
            end else begin
                for (i = 0; i < slots_used; i++) begin
                    if (!hit && slot_valid[i] && slot_len[i] >= cmd.req_size) begin
                        rest = slot_len[i] - cmd.req_size;
                        if (rest == '0) begin
                            slot_valid[i] = 1'b0;
                        end else begin
                            slot_len[i] = rest;
                        end
                        res.alloc_addr = slot_base[i] + rest;
                        hit = 1'b1;
                    end
                end
                if (hit) begin
                    n_hit++;
                end else begin
                    res.status = STAT_NOFIT;
                    n_miss++;
                end
            end
            expected_q.push_back(res);
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 20) begin
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
        endtask

        task check_result(t_out_beat got);
            t_out_beat want;
            if (expected_q.size() == 0) begin
                report_mismatch("result beat with nothing outstanding");
                return;
            end
            want = expected_q.pop_front();
            n_checked++;
            if (got.status !== want.status) begin
                report_mismatch($sformatf("status %0d, expected %0d",
                                          got.status, want.status));
            end
            if (got.alloc_addr !== want.alloc_addr) begin
                report_mismatch($sformatf("alloc_addr %h, expected %h",
                                          got.alloc_addr, want.alloc_addr));
            end
        endtask

        // size of a random live block, for requests that land on real entries
        function bit pick_len(output logic [31:0] len);
            int live [$];
            len = '0;
            foreach (slot_valid[i]) begin
                if (i < slots_used && slot_valid[i]) live.push_back(i);
            end
            if (live.size() == 0) return 1'b0;
            len = slot_len[live[$urandom_range(live.size() - 1, 0)]];
            return 1'b1;
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_beat  i_item;
    logic      o_done;
    t_out_beat o_result;

    alloc_scoreboard sb;
    int              cycle_count = 0;
    int              idle_pct [4] = '{0, 71, 0, 20};

    first_fit_allocator uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("first_fit_allocator_test: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            sb.check_result(o_result);
        end
    end

    task automatic send_beat(input t_in_beat cmd);
        i_item <= cmd;
        start  <= 1'b1;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        sb.note_command(cmd);
    endtask

    task automatic send_cmd(input logic op, input logic [31:0] addr,
                            input logic [31:0] size);
        t_in_beat cmd;
        cmd.op         = op;
        cmd.block_addr = addr;
        cmd.req_size   = size;
        send_beat(cmd);
    endtask

    task automatic idle_gap(input int pct);
        while ($urandom_range(99, 0) < pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    function automatic t_in_beat random_cmd();
        t_in_beat    cmd;
        logic [31:0] len;
        bit          have;
        int          r;
        cmd.op         = ($urandom_range(99, 0) < 4) ? OP_APPEND : OP_ALLOC;
        cmd.block_addr = $urandom();
        cmd.req_size   = $urandom();
        r              = $urandom_range(99, 0);
        if (cmd.op == OP_APPEND) begin
            if (r < 10) begin
                cmd.req_size = '0;
            end else if (r < 35) begin
                cmd.req_size = $urandom_range(65535, 1);
            end
        end else begin
            have = sb.pick_len(len);
            if (have && r < 10) begin
                cmd.req_size = len;
            end else if (have && r < 22) begin
                cmd.req_size = $urandom_range(len, 0);
            end else if (have && r < 30) begin
                cmd.req_size = len + 32'd1;
            end else if (r < 40) begin
                cmd.req_size = '0;
            end else if (r < 75) begin
                cmd.req_size = $urandom_range(4096, 1);
            end
        end
        return cmd;
    endfunction

    initial begin
        sb = new();
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_item  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table, zero-size block, zero-size request, wrap, exact fits
        send_cmd(OP_ALLOC,  32'h0000_0000, 32'h0000_0000);
        send_cmd(OP_ALLOC,  32'hFFFF_FFFF, 32'h0000_0005);
        send_cmd(OP_APPEND, 32'h0000_1000, 32'h0000_0000);
        send_cmd(OP_ALLOC,  32'h0000_0000, 32'h0000_0001);
        send_cmd(OP_APPEND, 32'hFFFF_FFF0, 32'h0000_0100);
        send_cmd(OP_ALLOC,  32'h0000_0000, 32'h0000_0000);
        send_cmd(OP_ALLOC,  32'h0000_0000, 32'h0000_0000);
        send_cmd(OP_ALLOC,  32'h0000_0000, 32'h0000_0010);
        send_cmd(OP_APPEND, 32'h0000_0000, 32'hFFFF_FFFF);
        send_cmd(OP_ALLOC,  32'h0000_0000, 32'hFFFF_FFFF);
        send_cmd(OP_ALLOC,  32'h0000_0000, 32'h0000_00F0);
        send_cmd(OP_ALLOC,  32'h0000_0000, 32'h0000_00F0);
        send_cmd(OP_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(OP_ALLOC,  32'h0000_0000, 32'h0000_0001);
        send_cmd(OP_ALLOC,  32'hFFFF_FFFF, 32'h8000_0000);
        send_cmd(OP_ALLOC,  32'h0000_0000, 32'h8000_0000);

        foreach (idle_pct[p]) begin
            for (int k = 0; k < RANDOM_BEATS / 4; k++) begin
                idle_gap(idle_pct[p]);
                send_beat(random_cmd());
            end
        end
        start <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("run covered %0d blocks placed, %0d appends refused on a full table",
                 sb.n_placed, sb.n_full);
        $display("%0d allocations fitted, %0d found no fit, %0d result beats checked",
                 sb.n_hit, sb.n_miss, sb.n_checked);
        if (sb.errors == 0) begin
            $display("first_fit_allocator_test: PASS");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("first_fit_allocator_test: FAIL");
        end
        $finish;
    end

endmodule
